@@ rtl/rrwca_pkg.sv @@
// Types, constants and codes shared by the receive reorder window.
package rrwca_pkg;

   localparam int WINDOW        = 64;   // slots; a power of two
   localparam int PAYLOAD_WIDTH = 64;
   localparam int DRAIN_MAX     = 16;
   localparam int RESULT_CAP    = 16;
   localparam int DRAIN_LIMIT   = (DRAIN_MAX < RESULT_CAP) ? DRAIN_MAX : RESULT_CAP;
   localparam int SCAN_STEP     = 8;    // slots examined per cycle by the run scan

   localparam int IDX_W = $clog2(WINDOW);
   localparam int RUN_W = $clog2(WINDOW + 1);
   localparam int CNT_W = $clog2(DRAIN_LIMIT + 1);

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_DRAIN   = 1'b1;

   typedef enum logic [1:0] {
      RK_ACK   = 2'd0,
      RK_DATA  = 2'd1,
      RK_EMPTY = 2'd2
   } rkind_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] seq;
      logic [31:0] stamp;
      logic        fin;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      rkind_type   rkind;
      logic [31:0] ack_seq;
      logic [31:0] echo_stamp;
      logic [63:0] data_word;
      logic        end_of_file;
      logic        last;
      logic        out_of_window;
   } rsp_type;

endpackage

@@ rtl/receive_reorder_window_cumulative_ack.sv @@
// Receive reorder window: stores arrivals by sequence number, acks cumulatively, drains in order.
//
// Usage: drive req_item and raise start; the item is taken at an edge where busy is low.
// An arrival (kind 0) yields one acknowledgement item on rsp_item, marked by rsp_strobe
// for one cycle: the base plus the run of filled slots, echoing the stamp. An arrival
// outside the window, or any arrival after the final packet was drained, is dropped
// and flagged with out_of_window.
// An arrival that does not touch the slot right after the filled run is acked in the cycle
// after it is taken and the block is free again at once. An arrival that fills that slot
// extends the run with a scan of 8 slots per cycle, and its ack follows once the scan stops.
// A drain (kind 1) starts one payload memory read and then delivers one word per cycle
// from the base, up to 16, stopping after the end-of-file word or at the first empty slot;
// the last word carries last. A drain with nothing ready answers one empty item.
// Payload words sit in a memory with one write port and one registered read port; slot
// fill bits are flip-flops that reset clears, so no clearing pass is needed.
// Reset (synchronous, active high) empties the window and sets the base to zero.
// The receiver cannot stall: every result is present for exactly one cycle.
module receive_reorder_window_cumulative_ack (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrwca_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rrwca_pkg::rsp_type rsp_item
);

   localparam int IDX_W = rrwca_pkg::IDX_W;
   localparam int RUN_W = rrwca_pkg::RUN_W;
   localparam int CNT_W = rrwca_pkg::CNT_W;
   localparam int PW    = rrwca_pkg::PAYLOAD_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type                      state_ff, state_in;
   logic [31:0]                    base_ff, base_in;
   logic [RUN_W-1:0]               run_ff, run_in;
   logic [rrwca_pkg::WINDOW-1:0]   filled_ff, filled_in;
   logic                           finished_ff, finished_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [31:0]                    stamp_ff, stamp_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   rrwca_pkg::rsp_type             rsp_ff, rsp_in;

   // payload memory: final mark on top of the word
   logic [PW:0]                    slot_mem [rrwca_pkg::WINDOW];
   logic [PW:0]                    rd_data_ff;
   logic [IDX_W-1:0]               rd_addr;
   logic                           mem_we;
   logic [IDX_W-1:0]               wr_addr;
   logic [PW:0]                    wr_data;

   logic [31:0]                    offset;
   logic                           drop;
   logic [IDX_W-1:0]               base_idx;
   logic [IDX_W-1:0]               next_idx;
   logic [31:0]                    base_next;

   assign base_idx  = base_ff[IDX_W-1:0];
   assign base_next = base_ff + 32'd1;
   assign next_idx  = base_next[IDX_W-1:0];
   assign offset    = req_item.seq - base_ff;
   assign drop      = finished_ff || (offset >= 32'(rrwca_pkg::WINDOW));
   assign wr_addr   = req_item.seq[IDX_W-1:0];
   assign wr_data   = {req_item.fin, req_item.payload[PW-1:0]};

   always_comb begin
      logic             stop;
      logic [RUN_W-1:0] pos;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt_next;
      logic             is_final;
      logic             done;

      state_in      = state_ff;
      base_in       = base_ff;
      run_in        = run_ff;
      filled_in     = filled_ff;
      finished_in   = finished_ff;
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.rkind  = rrwca_pkg::RK_ACK;
      mem_we        = 1'b0;
      rd_addr       = base_idx;
      stop          = 1'b0;
      pos           = '0;
      idx           = '0;
      cnt_next      = count_ff + CNT_W'(1);
      is_final      = rd_data_ff[PW];
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.kind == rrwca_pkg::KIND_ARRIVAL) begin
                  rsp_in.rkind         = rrwca_pkg::RK_ACK;
                  rsp_in.echo_stamp    = req_item.stamp;
                  rsp_in.out_of_window = drop;
                  rsp_in.last          = 1'b1;
                  if (!drop) begin
                     mem_we                       = 1'b1;
                     filled_in[offset[IDX_W-1:0] + base_idx] = 1'b1;
                  end
                  if (!drop && (offset[RUN_W-1:0] == run_ff)) begin
                     // slot right after the run filled: extend the run
                     run_in   = offset[RUN_W-1:0] + RUN_W'(1);
                     stamp_in = req_item.stamp;
                     state_in = ST_SCAN;
                  end else begin
                     rsp_in.ack_seq = base_ff + 32'(run_ff);
                     rsp_strobe_in  = 1'b1;
                  end
               end else begin
                  if (finished_ff || !filled_ff[base_idx]) begin
                     rsp_in.rkind   = rrwca_pkg::RK_EMPTY;
                     rsp_in.ack_seq = base_ff;
                     rsp_in.last    = 1'b1;
                     rsp_strobe_in  = 1'b1;
                  end else begin
                     count_in = '0;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_SCAN: begin
            for (int j = 0; j < rrwca_pkg::SCAN_STEP; j++) begin
               pos = run_ff + RUN_W'(j);
               idx = base_idx + pos[IDX_W-1:0];
               if (!stop) begin
                  if ((pos < RUN_W'(rrwca_pkg::WINDOW)) && filled_ff[idx]) begin
                     run_in = pos + RUN_W'(1);
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            if (stop) begin
               rsp_in.rkind      = rrwca_pkg::RK_ACK;
               rsp_in.ack_seq    = base_ff + 32'(run_in);
               rsp_in.echo_stamp = stamp_ff;
               rsp_in.last       = 1'b1;
               rsp_strobe_in     = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            done = is_final || (cnt_next == CNT_W'(rrwca_pkg::DRAIN_LIMIT))
                   || !filled_ff[next_idx];
            filled_in[base_idx] = 1'b0;
            base_in             = base_next;
            run_in              = run_ff - RUN_W'(1);
            count_in            = cnt_next;
            finished_in         = finished_ff || is_final;
            rd_addr             = next_idx;
            rsp_in.rkind        = rrwca_pkg::RK_DATA;
            rsp_in.ack_seq      = base_next;
            rsp_in.data_word    = 64'(rd_data_ff[PW-1:0]);
            rsp_in.end_of_file  = is_final;
            rsp_in.last         = done;
            rsp_strobe_in       = 1'b1;
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         run_ff        <= '0;
         filled_ff     <= '0;
         finished_ff   <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         run_ff        <= run_in;
         filled_ff     <= filled_in;
         finished_ff   <= finished_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      stamp_ff <= stamp_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_W'(rrwca_pkg::WINDOW))
      else $error("filled run exceeds window");

   a_drain_base_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> filled_ff[base_idx] && !finished_ff)
      else $error("drain reads an empty base slot");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.rkind == rrwca_pkg::RK_DATA && rsp_item.end_of_file)
      |-> rsp_item.last)
      else $error("end-of-file word not marked last");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (run_ff != '0) && filled_ff[base_idx])
      else $error("run scan started on an empty base");

   a_final_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.rkind == rrwca_pkg::RK_DATA && rsp_item.end_of_file)
      |-> finished_ff && !busy)
      else $error("drain continued past end of file");
`endif

endmodule

@@ test/receive_reorder_window_cumulative_ack_tb.sv @@
// Self-checking bench for the receive reorder window: table-driven directed items, then random batches.
module receive_reorder_window_cumulative_ack_tb;

   localparam int DIRECTED_ROWS = 16;
   localparam logic [31:0] DIRECTED_END_BASE = 32'd5;   // base once the table has run
   localparam int RANDOM_ITEMS = 300;
   localparam int CALM_TAIL = 40;                       // items at the end with no gaps
   localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - rrwca_pkg::PAYLOAD_WIDTH);

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_HELD  = 2'd1,
      SLOT_LAST  = 2'd2
   } slot_fill_type;

   typedef struct packed {
      rrwca_pkg::req_type it;
      logic               typed;
      rrwca_pkg::rsp_type want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   rrwca_pkg::req_type req_item;
   logic               rsp_strobe;
   rrwca_pkg::rsp_type rsp_item;

   // per-item tag: a typed-in result replaces the predicted one
   logic               row_typed;
   rrwca_pkg::rsp_type row_want;

   // window as the bench sees it
   slot_fill_type slot_fill [rrwca_pkg::WINDOW];
   logic [63:0]   slot_word [rrwca_pkg::WINDOW];
   logic [31:0]   base_seq;
   logic          eof_drained;

   rrwca_pkg::rsp_type responses_due [$];

   int errors = 0;
   int items_sent = 0;
   int arrivals_seen = 0;
   int arrivals_dropped = 0;
   int drains_seen = 0;
   int words_delivered = 0;
   bit allow_idle;
   logic [31:0] next_base;

   receive_reorder_window_cumulative_ack DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // Push the results one accepted item causes, and advance the window.
   function automatic void window_response(input rrwca_pkg::req_type it);
      rrwca_pkg::rsp_type r;
      rrwca_pkg::rsp_type held;
      logic [31:0]        offset;
      logic               drop;
      int                 run;
      int                 idx;
      int                 n;
      bit                 scanning;
      slot_fill_type      m;
      if (it.kind == rrwca_pkg::KIND_ARRIVAL) begin
         arrivals_seen++;
         offset = it.seq - base_seq;
         drop = eof_drained || (offset >= rrwca_pkg::WINDOW);
         if (!drop) begin
            idx = it.seq % rrwca_pkg::WINDOW;
            slot_word[idx] = it.payload & WORD_MASK;
            slot_fill[idx] = it.fin ? SLOT_LAST : SLOT_HELD;
         end else begin
            arrivals_dropped++;
         end
         run = 0;
         scanning = 1'b1;
         while (scanning && run < rrwca_pkg::WINDOW) begin
            if (slot_fill[(base_seq + run) % rrwca_pkg::WINDOW] == SLOT_EMPTY) scanning = 1'b0;
            else run++;
         end
         r = '{rrwca_pkg::RK_ACK, base_seq + run, it.stamp, 64'd0, 1'b0, 1'b1, drop};
         responses_due.push_back(r);
      end else begin
         drains_seen++;
         n = 0;
         scanning = !eof_drained;
         while (scanning && n < rrwca_pkg::DRAIN_LIMIT) begin
            idx = base_seq % rrwca_pkg::WINDOW;
            m = slot_fill[idx];
            if (m == SLOT_EMPTY) begin
               scanning = 1'b0;
            end else begin
               slot_fill[idx] = SLOT_EMPTY;
               base_seq++;
               if (m == SLOT_LAST) begin
                  eof_drained = 1'b1;
                  scanning = 1'b0;
               end
               r = '{rrwca_pkg::RK_DATA, base_seq, 32'd0, slot_word[idx], m == SLOT_LAST,
                     1'b0, 1'b0};
               if (n > 0) responses_due.push_back(held);
               held = r;
               n++;
            end
         end
         words_delivered += n;
         if (n == 0) begin
            r = '{rrwca_pkg::RK_EMPTY, base_seq, 32'd0, 64'd0, 1'b0, 1'b1, 1'b0};
            responses_due.push_back(r);
         end else begin
            held.last = 1'b1;
            responses_due.push_back(held);
         end
      end
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want_v,
                                         input logic [63:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      rrwca_pkg::rsp_type want;
      if (!reset && start && !busy) begin
         window_response(req_item);
         if (row_typed) begin
            void'(responses_due.pop_back());
            responses_due.push_back(row_want);
         end
      end
      if (!reset && rsp_strobe) begin
         if (responses_due.size() == 0) begin
            errors++;
            $display("%0t: result expected none actual %h", $time, rsp_item);
         end else begin
            want = responses_due.pop_front();
            compare_field("rkind", 64'(want.rkind), 64'(rsp_item.rkind));
            compare_field("ack_seq", 64'(want.ack_seq), 64'(rsp_item.ack_seq));
            compare_field("echo_stamp", 64'(want.echo_stamp), 64'(rsp_item.echo_stamp));
            compare_field("data_word", want.data_word, rsp_item.data_word);
            compare_field("end_of_file", 64'(want.end_of_file), 64'(rsp_item.end_of_file));
            compare_field("last", 64'(want.last), 64'(rsp_item.last));
            compare_field("out_of_window", 64'(want.out_of_window),
                          64'(rsp_item.out_of_window));
         end
      end
   end

   function automatic rrwca_pkg::req_type arrival_req(input logic [31:0] seq,
                                                      input logic [31:0] stamp,
                                                      input logic fin,
                                                      input logic [63:0] payload);
      return '{rrwca_pkg::KIND_ARRIVAL, seq, stamp, fin, payload};
   endfunction

   function automatic rrwca_pkg::req_type drain_req();
      return '{rrwca_pkg::KIND_DRAIN, 32'($urandom), 32'($urandom), 1'($urandom_range(0, 1)),
               {32'($urandom), 32'($urandom)}};
   endfunction

   function automatic rrwca_pkg::rsp_type typed_ack(input logic [31:0] ack,
                                                    input logic [31:0] echo,
                                                    input logic oow);
      return '{rrwca_pkg::RK_ACK, ack, echo, 64'd0, 1'b0, 1'b1, oow};
   endfunction

   // Hold the item until taken, then maybe idle for a short burst.
   task automatic send_item(input rrwca_pkg::req_type it, input logic typed,
                            input rrwca_pkg::rsp_type want);
      req_item <= it;
      row_typed <= typed;
      row_want <= want;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic arrive(input logic [31:0] seq, input logic fin);
      send_item(arrival_req(seq, $urandom, fin, {32'($urandom), 32'($urandom)}), 1'b0, '0);
   endtask

   task automatic drain();
      send_item(drain_req(), 1'b0, '0);
   endtask

   // Arrival that lands outside the window: ahead of it, behind the base, or anywhere.
   task automatic stray_arrival();
      case ($urandom_range(0, 2))
         0: arrive(next_base + 84 + $urandom_range(0, 10000), 1'($urandom_range(0, 1)));
         1: arrive(next_base - 1 - $urandom_range(0, 1000), 1'($urandom_range(0, 1)));
         default: arrive($urandom, 1'b0);
      endcase
   endtask

   // Fill next_base .. next_base+n-1 in shuffled order, then drain it up to its end-of-file word, if any.
   task automatic run_batch(input int n, input bit full, input int fin_at);
      int order [rrwca_pkg::WINDOW];
      int j;
      int t;
      int drains;
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) stray_arrival();
         // a full-window batch must see no drain until every slot is filled
         if (!full && $urandom_range(0, 4) == 0) drain();
         // an end-of-file mark overwritten at once keeps the transfer open
         if (fin_at < 0 && $urandom_range(0, 9) == 0) arrive(next_base + order[i], 1'b1);
         arrive(next_base + order[i], order[i] == fin_at);
         if (fin_at < 0 && i > 0 && $urandom_range(0, 9) == 0)
            arrive(next_base + order[$urandom_range(0, i - 1)], 1'b0);
      end
      drains = (n + 15) / 16 + $urandom_range(0, 1);
      for (int d = 0; d < drains; d++) drain();
      next_base += n;
   endtask

   initial begin : stimulus
      directed_row_type plan [DIRECTED_ROWS];
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      row_typed = 1'b0;
      row_want = '0;
      for (int i = 0; i < rrwca_pkg::WINDOW; i++) begin
         slot_fill[i] = SLOT_EMPTY;
         slot_word[i] = '0;
      end
      base_seq = '0;
      eof_drained = 1'b0;
      allow_idle = 1'b1;

      plan[0]  = '{drain_req(), 1'b1,
                   '{rrwca_pkg::RK_EMPTY, 32'd0, 32'd0, 64'd0, 1'b0, 1'b1, 1'b0}};
      plan[1]  = '{arrival_req(32'd64, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
                   typed_ack(32'd0, 32'hFFFF_FFFF, 1'b1)};
      plan[2]  = '{arrival_req(32'hFFFF_FFFF, 32'd0, 1'b0, 64'd0), 1'b1,
                   typed_ack(32'd0, 32'd0, 1'b1)};
      plan[3]  = '{arrival_req(32'd63, 32'h1234_5678, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
                   typed_ack(32'd0, 32'h1234_5678, 1'b0)};
      plan[4]  = '{arrival_req(32'd1, 32'd0, 1'b0, 64'd0), 1'b1,
                   typed_ack(32'd0, 32'd0, 1'b0)};
      plan[5]  = '{arrival_req(32'd0, 32'h8000_0001, 1'b0, 64'h8000_0000_0000_0001), 1'b0, '0};
      plan[6]  = '{arrival_req(32'd1, 32'h7FFF_FFFF, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA), 1'b0, '0};
      plan[7]  = '{drain_req(), 1'b0, '0};
      plan[8]  = '{drain_req(), 1'b0, '0};
      plan[9]  = '{arrival_req(32'd2, 32'h0F0F_0F0F, 1'b1, 64'h5555_5555_5555_5555), 1'b0, '0};
      plan[10] = '{arrival_req(32'd2, 32'hF0F0_F0F0, 1'b0, 64'h0123_4567_89AB_CDEF), 1'b0, '0};
      plan[11] = '{arrival_req(32'd4, 32'h0000_0001, 1'b0, 64'hFEDC_BA98_7654_3210), 1'b0, '0};
      plan[12] = '{arrival_req(32'd3, 32'h8000_0000, 1'b0, 64'h0000_0000_FFFF_FFFF), 1'b0, '0};
      plan[13] = '{drain_req(), 1'b0, '0};
      // last slot inside the window, then the first one past it
      plan[14] = '{arrival_req(32'd68, 32'h3C3C_3C3C, 1'b0, 64'hFFFF_FFFF_0000_0000), 1'b0, '0};
      plan[15] = '{arrival_req(32'd69, 32'hC3C3_C3C3, 1'b0, 64'h1111_2222_3333_4444), 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_item(plan[i].it, plan[i].typed, plan[i].want);

      // the first batch fills every slot, including those the table left behind
      next_base = DIRECTED_END_BASE;
      run_batch(rrwca_pkg::WINDOW, 1'b1, -1);
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (items_sent >= DIRECTED_ROWS + RANDOM_ITEMS - CALM_TAIL) allow_idle = 1'b0;
         if ($urandom_range(0, 9) == 0) run_batch(rrwca_pkg::WINDOW, 1'b1, -1);
         else run_batch($urandom_range(1, 20), 1'b0, -1);
      end
      allow_idle = 1'b0;

      // close the transfer with words still queued behind the end-of-file slot
      n = $urandom_range(8, 20);
      run_batch(n, 1'b0, n - 4);
      arrive(next_base, 1'b0);
      arrive(next_base - 3, 1'b1);
      drain();
      arrive($urandom, 1'b0);
      drain();

      start <= 1'b0;
      @(posedge clock);
      while (responses_due.size() != 0) @(posedge clock);
      // a drain or a run scan may still be running; let any stray result show
      repeat (24) @(posedge clock);

      $display("covered %0d items: %0d arrivals (%0d dropped), %0d drains, %0d words delivered",
               items_sent, arrivals_seen, arrivals_dropped, drains_seen, words_delivered);
      $display("transfer %s, final base %0d", eof_drained ? "closed" : "still open", base_seq);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rrwca_pkg.sv
rtl/receive_reorder_window_cumulative_ack.sv
test/receive_reorder_window_cumulative_ack_tb.sv
